// ===== hdl/ppgd_pkg.sv =====
`timescale 1ns / 1ps
package ppgd_pkg;
    localparam int CoordW = 32;
    localparam int DistW = 32;
    localparam int StatusW = 2;
    localparam logic [StatusW-1:0] STATUS_OK = 2'd0;
    localparam logic [StatusW-1:0] STATUS_FEW = 2'd1;
    localparam logic [StatusW-1:0] STATUS_DROP = 2'd2;
    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    typedef struct packed {
        logic signed [CoordW-1:0] y;
        logic signed [CoordW-1:0] x;
    } point_t;

    typedef struct packed {
        logic [DistW-1:0] distance;
        logic [StatusW-1:0] status;
    } result_t;
endpackage

// ===== hdl/ppgd_ram.sv =====
`timescale 1ns / 1ps
module ppgd_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ===== hdl/ppgd_divsqrt.sv =====
`timescale 1ns / 1ps
module ppgd_divsqrt (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start_div,
    input  logic         start_sqrt,
    input  logic [127:0] num,
    input  logic [127:0] den,
    output logic         done,
    output logic [63:0]  res
);
    typedef enum logic [1:0] {IDLE, DIV, SQRT} state_t;
    state_t state_reg;
    logic [5:0] cnt_reg;
    logic [127:0] rem_reg;
    logic [127:0] den_reg;
    logic [63:0] q_reg;
    logic [45:0] acc_reg;
    logic [128:0] sh;
    logic [47:0] sq_rem;
    logic [47:0] sq_trial;

    always_comb
    begin
        sh = {rem_reg, 1'b0};
        sq_rem = {acc_reg, rem_reg[81:80]};
        sq_trial = {q_reg[45:0], 2'b01};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= IDLE;
            done <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            done <= 1'b0;
            case (state_reg)
                IDLE:
                begin
                    if (start_div)
                    begin
                        state_reg <= DIV;
                        rem_reg <= num;
                        den_reg <= den;
                        q_reg <= '0;
                        cnt_reg <= 6'd31;
                    end
                    else if (start_sqrt)
                    begin
                        state_reg <= SQRT;
                        rem_reg <= num;
                        acc_reg <= '0;
                        q_reg <= '0;
                        cnt_reg <= 6'd40;
                    end
                end
                DIV:
                begin
                    if (sh >= {1'b0, den_reg})
                    begin
                        rem_reg <= 128'(sh - {1'b0, den_reg});
                        q_reg <= {q_reg[62:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg <= sh[127:0];
                        q_reg <= {q_reg[62:0], 1'b0};
                    end
                    if (cnt_reg == 6'd0)
                    begin
                        state_reg <= IDLE;
                        done <= 1'b1;
                    end
                    cnt_reg <= cnt_reg - 6'd1;
                end
                SQRT:
                begin
                    if (sq_rem >= sq_trial)
                    begin
                        acc_reg <= 46'(sq_rem - sq_trial);
                        q_reg <= {q_reg[62:0], 1'b1};
                    end
                    else
                    begin
                        acc_reg <= sq_rem[45:0];
                        q_reg <= {q_reg[62:0], 1'b0};
                    end
                    rem_reg <= {rem_reg[125:0], 2'b00};
                    if (cnt_reg == 6'd0)
                    begin
                        state_reg <= IDLE;
                        done <= 1'b1;
                    end
                    cnt_reg <= cnt_reg - 6'd1;
                end
                default: state_reg <= IDLE;
            endcase
        end
    end

    assign res = q_reg;
endmodule

// ===== hdl/path_projection_goal_distance_core.sv =====
`timescale 1ns / 1ps
// A load transaction writes one point into the path RAM, or drops it and marks the path
// as dropped when the RAM is full. A query transaction scans every stored point
// through the RAM read port, one point per cycle, then rereads the two nearest points
// and the goal, runs a 32-step restoring divider for the fraction and a 41-step
// digit-by-digit square root; when the fraction clamps to 0 or 1 no division runs. A
// query with fewer than two points answers on the next cycle. The result waits in an
// output register, and no new transaction is accepted until it has been taken.
module path_projection_goal_distance_core #(
    parameter int MAX_POINTS = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,  // coord_x, coord_y
    input  logic [1:0]  s_tuser,  // mode, start_new
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,  // distance, status, zero fill
    output logic        m_tuser
);
    import ppgd_pkg::*;
    localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CW = $clog2(MAX_POINTS + 1);

    typedef enum logic [3:0] {
        IDLE, SCAN, SCAN_LAST, RD1, RD2, RDF, DOT, DIVW, OFS, SQS, SQW, OUT
    } state_t;
    state_t state_reg;

    logic [CW-1:0] count_reg;
    logic dropped_reg;
    logic [CW-1:0] idx_reg;
    logic signed [CoordW-1:0] vx_reg, vy_reg;
    logic [127:0] d1_reg, d2_reg;
    logic [AW-1:0] n1_reg, n2_reg, cur_reg;
    logic have1_reg, have2_reg, scanv_reg;
    logic signed [33:0] x1_reg, y1_reg, sx_reg, sy_reg, xf_reg, yf_reg;
    logic [127:0] len2_reg;
    logic [32:0] k_reg;
    logic signed [35:0] ex_reg, ey_reg;
    result_t res_reg;
    logic out_valid_reg;

    logic we;
    logic [AW-1:0] waddr, raddr;
    point_t rdata, wpt;
    logic start_div, start_sqrt, ds_done;
    logic [127:0] ds_num;
    logic [63:0] ds_res;

    logic signed [33:0] dx, dy, rx, ry;
    logic [127:0] dsq;
    logic signed [68:0] dotv;
    logic signed [68:0] px, py;
    logic load_acc, query_acc;
    logic [CW-1:0] base_cnt;
    logic [AW-1:0] last_idx;

    assign s_tready = (state_reg == IDLE) && !out_valid_reg;
    assign load_acc = s_tvalid && s_tready && (s_tuser[0] == MODE_LOAD);
    assign query_acc = s_tvalid && s_tready && (s_tuser[0] == MODE_QUERY);
    assign base_cnt = s_tuser[1] ? '0 : count_reg;
    assign we = load_acc && (base_cnt < CW'(MAX_POINTS));
    assign waddr = base_cnt[AW-1:0];
    assign wpt = '{y: s_tdata[63:32], x: s_tdata[31:0]};
    assign last_idx = AW'(count_reg - CW'(1));

    always_comb
    begin
        raddr = idx_reg[AW-1:0];
        if (state_reg == RD1) raddr = n1_reg;
        if (state_reg == RD2) raddr = n2_reg;
        if (state_reg == RDF) raddr = last_idx;
    end

    ppgd_ram #(.WIDTH(64), .DEPTH(MAX_POINTS)) u_ram (
        .clk(clk), .we(we), .waddr(waddr), .wdata(wpt), .raddr(raddr), .rdata(rdata)
    );

    always_comb
    begin
        dx = 34'(rdata.x) - 34'(vx_reg);
        dy = 34'(rdata.y) - 34'(vy_reg);
        dsq = 128'($unsigned(68'(dx * dx))) + 128'($unsigned(68'(dy * dy)));
        rx = 34'(vx_reg) - x1_reg;
        ry = 34'(vy_reg) - y1_reg;
        px = 69'(rx) * 69'(sx_reg);
        py = 69'(ry) * 69'(sy_reg);
        dotv = px + py;
    end

    assign start_div = (state_reg == DOT) && (len2_reg != '0) && (dotv > 0)
                       && (128'(dotv) < len2_reg);
    assign ds_num = (state_reg == DOT) ? 128'(dotv) :
                    128'($unsigned(72'(ex_reg * ex_reg))) +
                    128'($unsigned(72'(ey_reg * ey_reg)));
    assign start_sqrt = (state_reg == SQS);

    ppgd_divsqrt u_ds (
        .clk(clk), .rst_n(rst_n), .start_div(start_div), .start_sqrt(start_sqrt),
        .num(ds_num), .den(len2_reg), .done(ds_done), .res(ds_res)
    );

    logic signed [67:0] ofx, ofy;
    always_comb
    begin
        ofx = 68'($signed({1'b0, k_reg})) * 68'(sx_reg);
        ofy = 68'($signed({1'b0, k_reg})) * 68'(sy_reg);
    end

    function automatic logic signed [35:0] rnd(input logic signed [67:0] p);
        logic signed [67:0] m;
        logic signed [67:0] a;
        begin
            a = p[67] ? -p : p;
            m = (a + 68'sh80000000) >>> 32;
            rnd = p[67] ? -36'(m) : 36'(m);
        end
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= IDLE;
            count_reg <= '0;
            dropped_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            scanv_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && m_tready) out_valid_reg <= 1'b0;
            case (state_reg)
                IDLE:
                begin
                    if (load_acc)
                    begin
                        if (base_cnt < CW'(MAX_POINTS))
                        begin
                            count_reg <= base_cnt + CW'(1);
                            dropped_reg <= s_tuser[1] ? 1'b0 : dropped_reg;
                        end
                        else
                        begin
                            dropped_reg <= 1'b1;
                        end
                    end
                    else if (query_acc)
                    begin
                        vx_reg <= s_tdata[31:0];
                        vy_reg <= s_tdata[63:32];
                        if (count_reg < CW'(2))
                        begin
                            res_reg <= '{distance: '0, status: STATUS_FEW};
                            out_valid_reg <= 1'b1;
                        end
                        else
                        begin
                            idx_reg <= '0;
                            have1_reg <= 1'b0;
                            have2_reg <= 1'b0;
                            scanv_reg <= 1'b0;
                            state_reg <= SCAN;
                        end
                    end
                end
                SCAN:
                begin
                    scanv_reg <= 1'b1;
                    cur_reg <= idx_reg[AW-1:0];
                    if (scanv_reg)
                    begin
                        if (!have1_reg || dsq < d1_reg)
                        begin
                            n2_reg <= n1_reg; d2_reg <= d1_reg; have2_reg <= have1_reg;
                            n1_reg <= cur_reg; d1_reg <= dsq; have1_reg <= 1'b1;
                        end
                        else if (!have2_reg || dsq < d2_reg)
                        begin
                            n2_reg <= cur_reg; d2_reg <= dsq; have2_reg <= 1'b1;
                        end
                    end
                    if (idx_reg == count_reg - CW'(1))
                    begin
                        state_reg <= SCAN_LAST;
                        idx_reg <= '0;
                    end
                    else
                    begin
                        idx_reg <= idx_reg + CW'(1);
                    end
                end
                SCAN_LAST:
                begin
                    if (!have1_reg || dsq < d1_reg)
                    begin
                        n2_reg <= n1_reg; n1_reg <= cur_reg;
                    end
                    else if (!have2_reg || dsq < d2_reg)
                    begin
                        n2_reg <= cur_reg;
                    end
                    idx_reg <= CW'(0);
                    state_reg <= RD1;
                end
                RD1:
                begin
                    idx_reg <= CW'(n2_reg);
                    state_reg <= RD2;
                end
                RD2: state_reg <= RDF;
                RDF:
                begin
                    state_reg <= DOT;
                end
                DOT:
                begin
                    k_reg <= '0;
                    if (len2_reg != '0 && dotv > 0)
                    begin
                        if (128'(dotv) >= len2_reg)
                        begin
                            k_reg <= 33'h100000000;
                            state_reg <= OFS;
                        end
                        else
                        begin
                            state_reg <= DIVW;
                        end
                    end
                    else
                    begin
                        state_reg <= OFS;
                    end
                end
                DIVW:
                begin
                    if (ds_done)
                    begin
                        k_reg <= {1'b0, ds_res[31:0]};
                        state_reg <= OFS;
                    end
                end
                OFS: state_reg <= SQS;
                SQS: state_reg <= SQW;
                SQW:
                begin
                    if (ds_done)
                    begin
                        res_reg.distance <= (ds_res > 64'hFFFFFFFF) ? '1 : ds_res[31:0];
                        res_reg.status <= dropped_reg ? STATUS_DROP : STATUS_OK;
                        state_reg <= OUT;
                    end
                end
                OUT:
                begin
                    if (!out_valid_reg)
                    begin
                        out_valid_reg <= 1'b1;
                        state_reg <= IDLE;
                    end
                end
                default: state_reg <= IDLE;
            endcase
        end
    end

    // Datapath loads of the segment ends and goal, timed to the registered RAM read.
    always_ff @(posedge clk)
    begin
        if (state_reg == RD2)
        begin
            x1_reg <= 34'(rdata.x);
            y1_reg <= 34'(rdata.y);
        end
        if (state_reg == RDF)
        begin
            sx_reg <= 34'(rdata.x) - x1_reg;
            sy_reg <= 34'(rdata.y) - y1_reg;
        end
        if (state_reg == DOT)
        begin
            xf_reg <= 34'(rdata.x);
            yf_reg <= 34'(rdata.y);
        end
        if (state_reg == RDF)
        begin
            len2_reg <= 128'($unsigned(68'((34'(rdata.x) - x1_reg) * (34'(rdata.x) - x1_reg))))
                      + 128'($unsigned(68'((34'(rdata.y) - y1_reg) * (34'(rdata.y) - y1_reg))));
        end
        if (state_reg == OFS)
        begin
            ex_reg <= 36'(x1_reg) - 36'(xf_reg) + rnd(ofx);
            ey_reg <= 36'(y1_reg) - 36'(yf_reg) + rnd(ofy);
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata = {6'd0, res_reg.status, res_reg.distance};
    assign m_tuser = 1'b0;

    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> state_reg == IDLE)
        else $error("ready outside idle");
    a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(MAX_POINTS))
        else $error("point count overflow");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result lost");
endmodule

// ===== verif/path_projection_goal_distance_checker.sv =====
`timescale 1ns / 1ps
module path_projection_goal_distance_checker
    import ppgd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [63:0] s_tdata,
    input  logic [1:0]  s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [39:0] m_tdata,
    output int          fail_count,
    output int          pending
);
    localparam int Depth = 64;

    typedef logic signed [127:0] wide_t;

    logic signed [CoordW-1:0] path_x [Depth];
    logic signed [CoordW-1:0] path_y [Depth];
    int      path_len;
    bit      path_dropped;
    result_t goal_q [$];

    function automatic wide_t scale_offset(wide_t frac, wide_t d);
        wide_t m;
        wide_t p;
        m = (d < 0) ? -d : d;
        p = (frac * m + wide_t'(64'h8000_0000)) >>> 32;
        return (d < 0) ? -p : p;
    endfunction

    function automatic result_t goal_distance(logic signed [CoordW-1:0] vx,
                                              logic signed [CoordW-1:0] vy);
        result_t r;
        wide_t d, d1, d2, dx, dy, sx, sy, ax, ay, dot, len2, frac, ex, ey, s, root, c;
        int n1, n2;
        bit h1, h2;
        n1 = 0;
        n2 = 0;
        h1 = 0;
        h2 = 0;
        d1 = 0;
        d2 = 0;
        frac = 0;
        if (path_len < 2)
        begin
            r.distance = '0;
            r.status = STATUS_FEW;
            return r;
        end
        for (int i = 0; i < path_len; i++)
        begin
            dx = wide_t'(path_x[i]) - wide_t'(vx);
            dy = wide_t'(path_y[i]) - wide_t'(vy);
            d = dx * dx + dy * dy;
            if (!h1 || d < d1)
            begin
                n2 = n1;
                d2 = d1;
                h2 = h1;
                n1 = i;
                d1 = d;
                h1 = 1;
            end
            else if (!h2 || d < d2)
            begin
                n2 = i;
                d2 = d;
                h2 = 1;
            end
        end
        sx = wide_t'(path_x[n2]) - wide_t'(path_x[n1]);
        sy = wide_t'(path_y[n2]) - wide_t'(path_y[n1]);
        ax = wide_t'(vx) - wide_t'(path_x[n1]);
        ay = wide_t'(vy) - wide_t'(path_y[n1]);
        len2 = sx * sx + sy * sy;
        dot = ax * sx + ay * sy;
        if (len2 != 0 && dot > 0)
        begin
            if (dot >= len2)
                frac = wide_t'(1) <<< 32;
            else
                frac = (dot <<< 32) / len2;
        end
        ex = wide_t'(path_x[n1]) - wide_t'(path_x[path_len-1]) + scale_offset(frac, sx);
        ey = wide_t'(path_y[n1]) - wide_t'(path_y[path_len-1]) + scale_offset(frac, sy);
        s = ex * ex + ey * ey;
        root = 0;
        for (int b = 40; b >= 0; b--)
        begin
            c = root | (wide_t'(1) <<< b);
            if (c * c <= s)
                root = c;
        end
        r.distance = (root > wide_t'(64'hFFFF_FFFF)) ? '1 : root[31:0];
        r.status = path_dropped ? STATUS_DROP : STATUS_OK;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        result_t got;
        result_t want;
        if (!rst_n)
        begin
            path_len = 0;
            path_dropped = 0;
            fail_count = 0;
            goal_q.delete();
            pending = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got.distance = m_tdata[31:0];
                got.status = m_tdata[33:32];
                if (goal_q.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected result: distance=%h status=%0d",
                                 got.distance, got.status);
                end
                else
                begin
                    want = goal_q.pop_front();
                    if (got.distance !== want.distance || got.status !== want.status)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("mismatch: distance exp %h got %h, status exp %0d got %0d",
                                     want.distance, got.distance, want.status, got.status);
                    end
                end
            end
            if (s_tvalid && s_tready)
            begin
                if (s_tuser[0] == MODE_QUERY)
                begin
                    want = goal_distance(s_tdata[31:0], s_tdata[63:32]);
                    goal_q = {goal_q, want};
                end
                else
                begin
                    if (s_tuser[1])
                    begin
                        path_len = 0;
                        path_dropped = 0;
                    end
                    if (path_len < Depth)
                    begin
                        path_x[path_len] = s_tdata[31:0];
                        path_y[path_len] = s_tdata[63:32];
                        path_len++;
                    end
                    else
                        path_dropped = 1;
                end
            end
            pending = goal_q.size();
        end
    end
endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
module testbench;
    import ppgd_pkg::*;

    localparam int CycleLimit = 3000000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;
    logic        m_tuser;

    int fail_count;
    int pending;
    int cycles = 0;
    int n_loads = 0;
    int n_queries = 0;
    int n_overflows = 0;
    bit steady = 0;
    int hold_asks = 0;
    int hold_seen = 0;
    int hold_left = 0;

    path_projection_goal_distance_core dut (.*);

    path_projection_goal_distance_checker checker_i (
        .clk, .rst_n, .s_tvalid, .s_tready, .s_tdata, .s_tuser,
        .m_tvalid, .m_tready, .m_tdata, .fail_count, .pending
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CycleLimit)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (hold_asks != hold_seen)
        begin
            hold_seen <= hold_asks;
            hold_left <= 2000;
            m_tready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            m_tready <= 1'b0;
        end
        else
            m_tready <= steady ? 1'b1 : ($urandom_range(99) >= 35);
    end

    task automatic send(logic mode, logic start, logic [31:0] x, logic [31:0] y);
        if (!steady && $urandom_range(99) < 35)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(4, 1)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= {start, mode};
        s_tdata <= {y, x};
        do
            @(posedge clk);
        while (!s_tready);
        if (mode == MODE_QUERY)
            n_queries++;
        else
            n_loads++;
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    function automatic logic [31:0] near(logic [31:0] c, int spread);
        return c + $urandom_range(2 * spread) - spread;
    endfunction

    task automatic random_path();
        int len;
        int nq;
        logic [31:0] bx, by, step_x, step_y, px, py;
        int spread;
        len = ($urandom_range(9) == 0) ? $urandom_range(70, 30) : $urandom_range(12, 1);
        spread = ($urandom_range(3) == 0) ? 32'h7fff_ffff : 32'h0004_0000;
        bx = ($urandom_range(4) == 0) ? $urandom : near(0, 32'h0100_0000);
        by = ($urandom_range(4) == 0) ? $urandom : near(0, 32'h0100_0000);
        step_x = near(0, 32'h0002_0000);
        step_y = near(0, 32'h0002_0000);
        if (len > 64)
            n_overflows++;
        for (int i = 0; i < len; i++)
        begin
            px = (spread == 32'h7fff_ffff) ? $urandom : near(bx + step_x * i, 32'h8000);
            py = (spread == 32'h7fff_ffff) ? $urandom : near(by + step_y * i, 32'h8000);
            send(MODE_LOAD, i == 0, px, py);
        end
        nq = $urandom_range(4, 1);
        for (int i = 0; i < nq; i++)
        begin
            if (spread == 32'h7fff_ffff || $urandom_range(9) == 0)
                send(MODE_QUERY, 1'($urandom_range(1)), $urandom, $urandom);
            else
                send(MODE_QUERY, 1'($urandom_range(1)),
                     near(bx + step_x * $urandom_range(len), spread),
                     near(by + step_y * $urandom_range(len), spread));
        end
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send(MODE_QUERY, 1'b0, 0, 0);
        send(MODE_LOAD, 1'b1, 32'h0001_0000, 32'h0002_0000);
        send(MODE_QUERY, 1'b1, 0, 0);
        send(MODE_LOAD, 1'b0, 32'h7fff_ffff, 32'h8000_0000);
        send(MODE_QUERY, 1'b0, 32'h8000_0000, 32'h7fff_ffff);
        send(MODE_QUERY, 1'b0, 32'h7fff_ffff, 32'h7fff_ffff);
        send(MODE_LOAD, 1'b1, 32'h8000_0000, 32'h8000_0000);
        send(MODE_LOAD, 1'b0, 32'h7fff_ffff, 32'h7fff_ffff);
        send(MODE_QUERY, 1'b0, 32'h8000_0000, 32'h7fff_ffff);
        send(MODE_LOAD, 1'b1, 32'h0003_0000, 32'h0003_0000);
        send(MODE_LOAD, 1'b0, 32'h0003_0000, 32'h0003_0000);
        send(MODE_QUERY, 1'b0, 32'h0001_0000, 32'h0000_8000);
        send(MODE_LOAD, 1'b1, 0, 0);
        send(MODE_LOAD, 1'b0, 32'h0002_0000, 0);
        send(MODE_LOAD, 1'b0, 32'h0004_0000, 0);
        send(MODE_QUERY, 1'b0, 32'h0001_0000, 32'h0005_0000);
        send(MODE_QUERY, 1'b0, 32'hffff_0000, 32'h0000_1000);
        send(MODE_QUERY, 1'b0, 32'h0009_0000, 32'hfffe_0000);
        send(MODE_QUERY, 1'b0, 32'h0000_5555, 32'h0000_0001);
        drain();

        for (int i = 0; i < 66; i++)
            send(MODE_LOAD, i == 0, 32'h0001_0000 * i, 32'hffff_8000 * i);
        send(MODE_QUERY, 1'b0, 32'h0010_4000, 32'hfff0_0000);
        send(MODE_LOAD, 1'b1, 32'h1234_5678, 32'h9abc_def0);
        send(MODE_QUERY, 1'b0, 0, 0);

        hold_asks++;
        for (int i = 0; i < 20; i++)
            random_path();
        drain();

        while (n_loads + n_queries < 1200)
        begin
            steady = (n_loads + n_queries > 500 && n_loads + n_queries < 650);
            if ($urandom_range(99) < 85)
                random_path();
            else
                send(1'($urandom_range(1)), 1'($urandom_range(1)), $urandom, $urandom);
            if ($urandom_range(30) == 0)
                drain();
        end
        steady = 0;
        drain();
        repeat (200) @(posedge clk);

        $display("Ran %0d loads and %0d queries, %0d paths overran the store.",
                 n_loads, n_queries, n_overflows);
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule

// ===== sim.f =====
hdl/ppgd_pkg.sv
hdl/ppgd_ram.sv
hdl/ppgd_divsqrt.sv
hdl/path_projection_goal_distance_core.sv
verif/path_projection_goal_distance_checker.sv
verif/testbench.sv
